// ===== rtl/implicit_list_first_fit_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared property forms for the allocator checker, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILFFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define ILFFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/ilffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Allocator package
// Command and status codes, tag constants and the transfer payload types.
// ----------------------------------------------------------------------------
package ilffa_pkg;

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_FREE    = 2'd2;
  localparam logic [1:0] CMD_REALLOC = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;
  localparam logic [16:0] CHUNK_RESET = 17'd4096;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [23:0] request_size;
  } alloc_in_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic [16:0] copy_bytes;
  } alloc_out_t;

endpackage

// ===== rtl/implicit_list_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Implicit-list first-fit heap allocator
// Boundary-tag heap manager over an on-chip word store, driven by a
// sequencer that walks block tags one store access at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A command (init, allocate, free, reallocate) is transferred when start is
//   high and busy is low. busy then stays high while the sequencer works.
//   Exactly one result per command appears on out_data for a single cycle,
//   marked by out_valid; the receiver cannot hold it off, and busy is
//   already low in that cycle, so the next command may be transferred there.
//   Latency is data dependent: it grows with every block header visited
//   by the first-fit walk, with every coalescing step and with marking a
//   block allocated (longer when a tail is split off). All of it is set
//   by the sequencer, which makes at most one store read or one store
//   write per cycle, so commands never overlap: a new one is taken only
//   when busy is low.
//   The chunk size register is written over the cfg channel (always ready);
//   it should only be written while no command is in flight.
//   Reset clears the heap bounds and sets the chunk size to 4096. The store
//   itself is undefined until an init command builds the heap.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator_unit #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ilffa_pkg::alloc_in_t  in_data,
  output logic                  out_valid,
  output ilffa_pkg::alloc_out_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [16:0]           cfg_data
);

  localparam int WORDS     = HEAP_BYTES / 4;
  localparam int AW        = $clog2(WORDS);
  localparam int MERGE_MAX = HEAP_BYTES / 8;
  localparam int CW        = $clog2(MERGE_MAX + 1);
  localparam logic [31:0] HEAP_B  = 32'(HEAP_BYTES);
  localparam logic [29:0] WORDS_W = 30'(WORDS);
  localparam logic [CW-1:0] MERGE_LIM = CW'(MERGE_MAX);

  // Sequencer states.
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_DONE   = 6'd1;
  localparam logic [5:0] S_INIT0  = 6'd2;
  localparam logic [5:0] S_INIT1  = 6'd3;
  localparam logic [5:0] S_INIT2  = 6'd4;
  localparam logic [5:0] S_INIT3  = 6'd5;
  localparam logic [5:0] S_INITG  = 6'd6;
  localparam logic [5:0] S_AL0    = 6'd7;
  localparam logic [5:0] S_ALFF1  = 6'd8;
  localparam logic [5:0] S_ALFF2  = 6'd9;
  localparam logic [5:0] S_ALTF   = 6'd10;
  localparam logic [5:0] S_ALGR   = 6'd11;
  localparam logic [5:0] S_ALCV   = 6'd12;
  localparam logic [5:0] S_FR1    = 6'd13;
  localparam logic [5:0] S_FR2    = 6'd14;
  localparam logic [5:0] S_RE0    = 6'd15;
  localparam logic [5:0] S_REL    = 6'd16;
  localparam logic [5:0] S_REN1   = 6'd17;
  localparam logic [5:0] S_REW2   = 6'd18;
  localparam logic [5:0] S_RECV   = 6'd19;
  localparam logic [5:0] S_RETF   = 6'd20;
  localparam logic [5:0] S_REGR   = 6'd21;
  localparam logic [5:0] S_RET1   = 6'd22;
  localparam logic [5:0] S_REFB   = 6'd23;
  localparam logic [5:0] S_REAL   = 6'd24;
  localparam logic [5:0] S_MG0    = 6'd25;
  localparam logic [5:0] S_MG1    = 6'd26;
  localparam logic [5:0] S_MG2    = 6'd27;
  localparam logic [5:0] S_MG3    = 6'd28;
  localparam logic [5:0] S_MGW1   = 6'd29;
  localparam logic [5:0] S_MGW2   = 6'd30;
  localparam logic [5:0] S_GR0    = 6'd31;
  localparam logic [5:0] S_GR1    = 6'd32;
  localparam logic [5:0] S_GR2    = 6'd33;
  localparam logic [5:0] S_GRM    = 6'd34;
  localparam logic [5:0] S_CV0    = 6'd35;
  localparam logic [5:0] S_CV1    = 6'd36;
  localparam logic [5:0] S_CVS2   = 6'd37;
  localparam logic [5:0] S_CVS3   = 6'd38;
  localparam logic [5:0] S_CVS4   = 6'd39;
  localparam logic [5:0] S_CVU2   = 6'd40;
  localparam logic [5:0] S_TF0    = 6'd41;
  localparam logic [5:0] S_TF1    = 6'd42;
  localparam logic [5:0] S_TF2    = 6'd43;
  localparam logic [5:0] S_LV0    = 6'd44;
  localparam logic [5:0] S_LV1    = 6'd45;

  // The word store: one write and one registered read per cycle.
  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;
  logic        rd_oob_r;
  logic        re, we;
  logic [31:0] rpos, wpos, wdata;
  logic [31:0] rv;

  logic [5:0]  state_r, state_nxt;
  logic [5:0]  mret_r, mret_nxt, gret_r, gret_nxt, cret_r, cret_nxt;
  logic [5:0]  tret_r, tret_nxt, lret_r, lret_nxt, aret_r, aret_nxt;
  logic [5:0]  fret_r, fret_nxt;
  logic [31:0] ht_r, ht_nxt, ls_r, ls_nxt, em_r, em_nxt;
  logic [16:0] chunk_r, chunk_nxt;
  logic [31:0] a_r, a_nxt;
  logic [23:0] req_r, req_nxt;
  logic [31:0] need_r, need_nxt, p_r, p_nxt, s_r, s_nxt, pw_r, pw_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] c_r, c_nxt, tf_r, tf_nxt, ext_r, ext_nxt;
  logic        ok_r, ok_nxt, live_r, live_nxt;
  logic [31:0] lsz_r, lsz_nxt, oc_r, oc_nxt, tot_r, tot_nxt, res_r, res_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        cv_r, cv_nxt;
  logic [15:0] csrc_r, csrc_nxt, cdst_r, cdst_nxt;
  logic [16:0] cby_r, cby_nxt;
  logic        out_valid_r, out_valid_nxt;
  ilffa_pkg::alloc_out_t out_data_r, out_data_nxt;

  logic [31:0] chunk_eff;

  assign rv        = rd_oob_r ? 32'd0 : rdata_r;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Low three bits ignored, floor at the minimum block size.
  always_comb begin
    chunk_eff = {15'd0, chunk_r[16:3], 3'd0};
    if (chunk_eff < ilffa_pkg::MIN_BLOCK) begin
      chunk_eff = ilffa_pkg::MIN_BLOCK;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_oob_r <= (rpos[31:2] >= WORDS_W);
      if (rpos[31:2] < WORDS_W) begin
        rdata_r <= mem[rpos[AW+1:2]];
      end
    end
    if (we && (wpos[31:2] < WORDS_W)) begin
      mem[wpos[AW+1:2]] <= wdata;
    end
  end

  always_comb begin
    logic [31:0] sz, ps, nsz, tmp;
    sz  = '0;
    ps  = '0;
    nsz = '0;
    tmp = '0;
    state_nxt = state_r;
    mret_nxt = mret_r; gret_nxt = gret_r; cret_nxt = cret_r; tret_nxt = tret_r;
    lret_nxt = lret_r; aret_nxt = aret_r; fret_nxt = fret_r;
    ht_nxt = ht_r; ls_nxt = ls_r; em_nxt = em_r; chunk_nxt = chunk_r;
    a_nxt = a_r; req_nxt = req_r; need_nxt = need_r; p_nxt = p_r; s_nxt = s_r;
    pw_nxt = pw_r; cnt_nxt = cnt_r; c_nxt = c_r; tf_nxt = tf_r; ext_nxt = ext_r;
    ok_nxt = ok_r; live_nxt = live_r; lsz_nxt = lsz_r; oc_nxt = oc_r;
    tot_nxt = tot_r; res_nxt = res_r; st_nxt = st_r; cv_nxt = cv_r;
    csrc_nxt = csrc_r; cdst_nxt = cdst_r; cby_nxt = cby_r;
    out_valid_nxt = 1'b0;
    out_data_nxt = out_data_r;
    re = 1'b0; rpos = '0; we = 1'b0; wpos = '0; wdata = '0;

    if (cfg_valid && cfg_ready) begin
      chunk_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt    = {16'd0, in_data.address};
          req_nxt  = in_data.request_size;
          st_nxt   = ilffa_pkg::ST_OK;
          res_nxt  = '0;
          cv_nxt   = 1'b0;
          csrc_nxt = '0;
          cdst_nxt = '0;
          cby_nxt  = '0;
          unique case (in_data.cmd)
            ilffa_pkg::CMD_INIT:  state_nxt = S_INIT0;
            ilffa_pkg::CMD_ALLOC: begin
              aret_nxt  = S_DONE;
              state_nxt = S_AL0;
            end
            ilffa_pkg::CMD_FREE: begin
              lret_nxt  = S_FR1;
              fret_nxt  = S_DONE;
              state_nxt = S_LV0;
            end
            default: state_nxt = S_RE0;
          endcase
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.result_address = res_r[15:0];
        out_data_nxt.status         = st_r;
        out_data_nxt.copy_valid     = cv_r;
        out_data_nxt.copy_source    = csrc_r;
        out_data_nxt.copy_dest      = cdst_r;
        out_data_nxt.copy_bytes     = cby_r;
        state_nxt = S_IDLE;
      end

      // Prologue and end marker, then the first chunk.
      S_INIT0: begin
        ht_nxt = 32'd16;
        we = 1'b1; wpos = 32'd0; wdata = 32'd0;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        we = 1'b1; wpos = 32'd4; wdata = 32'd9;
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        we = 1'b1; wpos = 32'd8; wdata = 32'd9;
        state_nxt = S_INIT3;
      end
      S_INIT3: begin
        we = 1'b1; wpos = 32'd12; wdata = 32'd1;
        ls_nxt = 32'd8;
        em_nxt = 32'd12;
        ext_nxt = chunk_eff;
        gret_nxt = S_INITG;
        state_nxt = S_GR0;
      end
      S_INITG: begin
        st_nxt = ok_r ? ilffa_pkg::ST_OK : ilffa_pkg::ST_OOM;
        state_nxt = S_DONE;
      end

      // Allocate.
      S_AL0: begin
        if (req_r == 24'd0) begin
          st_nxt = ilffa_pkg::ST_NULL;
          res_nxt = '0;
          state_nxt = aret_r;
        end else if (ht_r == 32'd0) begin
          st_nxt = ilffa_pkg::ST_OOM;
          res_nxt = '0;
          state_nxt = aret_r;
        end else begin
          need_nxt = 32'd8 + ((32'(req_r) + 32'd7) & ilffa_pkg::SIZE_MASK);
          p_nxt = ls_r;
          state_nxt = S_ALFF1;
        end
      end
      S_ALFF1: begin
        if (p_r > ht_r) begin
          tret_nxt = S_ALTF;
          state_nxt = S_TF0;
        end else begin
          re = 1'b1; rpos = p_r - 32'd4;
          state_nxt = S_ALFF2;
        end
      end
      S_ALFF2: begin
        sz = rv & ilffa_pkg::SIZE_MASK;
        if (sz == 32'd0) begin
          tret_nxt = S_ALTF;
          state_nxt = S_TF0;
        end else if (!rv[0] && (need_r <= sz)) begin
          cret_nxt = S_ALCV;
          state_nxt = S_CV0;
        end else if (sz > ht_r - p_r) begin
          tret_nxt = S_ALTF;
          state_nxt = S_TF0;
        end else begin
          p_nxt = p_r + sz;
          state_nxt = S_ALFF1;
        end
      end
      S_ALTF: begin
        tmp = (need_r > chunk_eff) ? need_r : chunk_eff;
        ext_nxt = tmp - tf_r;
        gret_nxt = S_ALGR;
        state_nxt = S_GR0;
      end
      S_ALGR: begin
        if (!ok_r) begin
          st_nxt = ilffa_pkg::ST_OOM;
          res_nxt = '0;
          state_nxt = aret_r;
        end else begin
          cret_nxt = S_ALCV;
          state_nxt = S_CV0;
        end
      end
      S_ALCV: begin
        st_nxt = ilffa_pkg::ST_OK;
        res_nxt = p_r;
        state_nxt = aret_r;
      end

      // Free: clear the allocated bit in both tags, then coalesce.
      S_FR1: begin
        if (!live_r) begin
          state_nxt = fret_r;
        end else begin
          we = 1'b1; wpos = a_r - 32'd4; wdata = lsz_r;
          state_nxt = S_FR2;
        end
      end
      S_FR2: begin
        we = 1'b1; wpos = a_r + lsz_r - 32'd8; wdata = lsz_r;
        p_nxt = a_r;
        cnt_nxt = '0;
        mret_nxt = fret_r;
        state_nxt = S_MG0;
      end

      // Reallocate.
      S_RE0: begin
        if (a_r == 32'd0) begin
          aret_nxt = S_DONE;
          state_nxt = S_AL0;
        end else if (ht_r == 32'd0) begin
          st_nxt = ilffa_pkg::ST_OOM;
          state_nxt = S_DONE;
        end else begin
          lret_nxt = S_REL;
          state_nxt = S_LV0;
        end
      end
      S_REL: begin
        need_nxt = 32'd8 + ((32'(req_r) + 32'd7) & ilffa_pkg::SIZE_MASK);
        oc_nxt = lsz_r;
        if (!live_r) begin
          st_nxt = ilffa_pkg::ST_NULL;
          state_nxt = S_DONE;
        end else if (req_r == 24'd0) begin
          st_nxt = ilffa_pkg::ST_NULL;
          fret_nxt = S_DONE;
          state_nxt = S_FR1;
        end else if (need_nxt <= lsz_r) begin
          p_nxt = a_r;
          cret_nxt = S_RECV;
          state_nxt = S_CV0;
        end else begin
          re = 1'b1; rpos = a_r + lsz_r - 32'd4;
          state_nxt = S_REN1;
        end
      end
      S_REN1: begin
        nsz = rv & ilffa_pkg::SIZE_MASK;
        if (!rv[0] && (oc_r + nsz >= need_r)) begin
          tot_nxt = oc_r + nsz;
          we = 1'b1; wpos = a_r - 32'd4; wdata = (oc_r + nsz) | 32'd1;
          state_nxt = S_REW2;
        end else if (nsz == 32'd0) begin
          tret_nxt = S_RETF;
          state_nxt = S_TF0;
        end else begin
          state_nxt = S_REFB;
        end
      end
      S_REW2: begin
        we = 1'b1; wpos = a_r + tot_r - 32'd8; wdata = tot_r | 32'd1;
        p_nxt = a_r;
        cret_nxt = S_RECV;
        state_nxt = S_CV0;
      end
      S_RECV: begin
        res_nxt = a_r;
        st_nxt = ilffa_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_RETF: begin
        tmp = need_r - oc_r - tf_r;
        ext_nxt = (tmp > chunk_eff) ? tmp : chunk_eff;
        gret_nxt = S_REGR;
        state_nxt = S_GR0;
      end
      S_REGR: begin
        if (ok_r) begin
          re = 1'b1; rpos = a_r + oc_r - 32'd4;
          state_nxt = S_RET1;
        end else begin
          state_nxt = S_REFB;
        end
      end
      S_RET1: begin
        tmp = oc_r + (rv & ilffa_pkg::SIZE_MASK);
        tot_nxt = tmp;
        we = 1'b1; wpos = a_r - 32'd4; wdata = tmp | 32'd1;
        state_nxt = S_REW2;
      end
      S_REFB: begin
        aret_nxt = S_REAL;
        state_nxt = S_AL0;
      end
      S_REAL: begin
        if (res_r == 32'd0) begin
          state_nxt = S_DONE;
        end else begin
          cv_nxt = 1'b1;
          csrc_nxt = a_r[15:0];
          cdst_nxt = res_r[15:0];
          tmp = (32'(req_r) < oc_r) ? 32'(req_r) : oc_r;
          cby_nxt = tmp[16:0];
          lret_nxt = S_FR1;
          fret_nxt = S_DONE;
          state_nxt = S_LV0;
        end
      end

      // Coalesce the free block at p_r with free neighbours.
      S_MG0: begin
        if (cnt_r == MERGE_LIM) begin
          state_nxt = mret_r;
        end else begin
          re = 1'b1; rpos = p_r - 32'd4;
          state_nxt = S_MG1;
        end
      end
      S_MG1: begin
        s_nxt = rv & ilffa_pkg::SIZE_MASK;
        re = 1'b1; rpos = p_r - 32'd8;
        state_nxt = S_MG2;
      end
      S_MG2: begin
        pw_nxt = rv;
        re = 1'b1; rpos = p_r + s_r - 32'd4;
        state_nxt = S_MG3;
      end
      S_MG3: begin
        ps  = pw_r & ilffa_pkg::SIZE_MASK;
        nsz = rv & ilffa_pkg::SIZE_MASK;
        if (pw_r[0] && rv[0]) begin
          state_nxt = mret_r;
        end else begin
          if (pw_r[0]) begin
            s_nxt = s_r + nsz;
          end else if (rv[0]) begin
            s_nxt = s_r + ps;
            p_nxt = p_r - ps;
          end else begin
            s_nxt = s_r + ps + nsz;
            p_nxt = p_r - ps;
          end
          state_nxt = S_MGW1;
        end
      end
      S_MGW1: begin
        we = 1'b1; wpos = p_r - 32'd4; wdata = s_r;
        state_nxt = S_MGW2;
      end
      S_MGW2: begin
        we = 1'b1; wpos = p_r + s_r - 32'd8; wdata = s_r;
        cnt_nxt = cnt_r + CW'(1);
        state_nxt = S_MG0;
      end

      // Extend the heap by ext_r bytes at its top.
      S_GR0: begin
        if ((ext_r == 32'd0) || (ext_r > HEAP_B - ht_r)) begin
          ok_nxt = 1'b0;
          state_nxt = gret_r;
        end else begin
          p_nxt = ht_r;
          we = 1'b1; wpos = ht_r - 32'd4; wdata = ext_r;
          state_nxt = S_GR1;
        end
      end
      S_GR1: begin
        we = 1'b1; wpos = p_r + ext_r - 32'd8; wdata = ext_r;
        state_nxt = S_GR2;
      end
      S_GR2: begin
        we = 1'b1; wpos = p_r + ext_r - 32'd4; wdata = 32'd1;
        em_nxt = p_r + ext_r - 32'd4;
        ht_nxt = ht_r + ext_r;
        cnt_nxt = '0;
        mret_nxt = S_GRM;
        state_nxt = S_MG0;
      end
      S_GRM: begin
        ok_nxt = 1'b1;
        state_nxt = gret_r;
      end

      // Mark the block at p_r allocated, splitting off a tail when large.
      S_CV0: begin
        re = 1'b1; rpos = p_r - 32'd4;
        state_nxt = S_CV1;
      end
      S_CV1: begin
        sz = rv & ilffa_pkg::SIZE_MASK;
        c_nxt = sz;
        if ((sz >= need_r) && (sz - need_r >= ilffa_pkg::MIN_BLOCK)) begin
          we = 1'b1; wpos = p_r - 32'd4; wdata = need_r | 32'd1;
          state_nxt = S_CVS2;
        end else begin
          we = 1'b1; wpos = p_r - 32'd4; wdata = sz | 32'd1;
          state_nxt = S_CVU2;
        end
      end
      S_CVS2: begin
        we = 1'b1; wpos = p_r + need_r - 32'd8; wdata = need_r | 32'd1;
        state_nxt = S_CVS3;
      end
      S_CVS3: begin
        we = 1'b1; wpos = p_r + need_r - 32'd4; wdata = c_r - need_r;
        state_nxt = S_CVS4;
      end
      S_CVS4: begin
        we = 1'b1; wpos = p_r + c_r - 32'd8; wdata = c_r - need_r;
        state_nxt = cret_r;
      end
      S_CVU2: begin
        we = 1'b1; wpos = p_r + c_r - 32'd8; wdata = c_r | 32'd1;
        state_nxt = cret_r;
      end

      // Size of a free block just below the end marker, else zero.
      S_TF0: begin
        re = 1'b1; rpos = em_r - 32'd4;
        state_nxt = S_TF1;
      end
      S_TF1: begin
        re = 1'b1; rpos = em_r - (rv & ilffa_pkg::SIZE_MASK);
        state_nxt = S_TF2;
      end
      S_TF2: begin
        tf_nxt = rv[0] ? 32'd0 : (rv & ilffa_pkg::SIZE_MASK);
        state_nxt = tret_r;
      end

      // Is a_r the payload of an allocated block?
      S_LV0: begin
        if ((ht_r == 32'd0) || (a_r[2:0] != 3'd0) || (a_r < 32'd16) ||
            (a_r - 32'd4 >= em_r)) begin
          live_nxt = 1'b0;
          state_nxt = lret_r;
        end else begin
          re = 1'b1; rpos = a_r - 32'd4;
          state_nxt = S_LV1;
        end
      end
      S_LV1: begin
        sz = rv & ilffa_pkg::SIZE_MASK;
        lsz_nxt = sz;
        live_nxt = rv[0] && (sz >= ilffa_pkg::MIN_BLOCK) &&
                   (sz <= em_r - (a_r - 32'd4));
        state_nxt = lret_r;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ht_r        <= '0;
      ls_r        <= '0;
      em_r        <= '0;
      chunk_r     <= ilffa_pkg::CHUNK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ht_r        <= ht_nxt;
      ls_r        <= ls_nxt;
      em_r        <= em_nxt;
      chunk_r     <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mret_r <= mret_nxt; gret_r <= gret_nxt; cret_r <= cret_nxt; tret_r <= tret_nxt;
    lret_r <= lret_nxt; aret_r <= aret_nxt; fret_r <= fret_nxt;
    a_r <= a_nxt; req_r <= req_nxt; need_r <= need_nxt; p_r <= p_nxt; s_r <= s_nxt;
    pw_r <= pw_nxt; cnt_r <= cnt_nxt; c_r <= c_nxt; tf_r <= tf_nxt; ext_r <= ext_nxt;
    ok_r <= ok_nxt; live_r <= live_nxt; lsz_r <= lsz_nxt; oc_r <= oc_nxt;
    tot_r <= tot_nxt; res_r <= res_nxt; st_r <= st_nxt; cv_r <= cv_nxt;
    csrc_r <= csrc_nxt; cdst_r <= cdst_nxt; cby_r <= cby_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/ilffa_checker.sv =====
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the command and result ports of the allocator over time.
// ----------------------------------------------------------------------------
`include "implicit_list_first_fit_allocator_unit_assert.svh"

module ilffa_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input ilffa_pkg::alloc_out_t out_data
);

  `ILFFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `ILFFA_ASSERT_IMP(a_result_idle, out_valid, !busy)
  `ILFFA_ASSERT_NXT(a_result_single, out_valid, !out_valid)
  `ILFFA_ASSERT_IMP(a_status_code, out_valid, out_data.status == ilffa_pkg::ST_OK || out_data.status == ilffa_pkg::ST_OOM || out_data.status == ilffa_pkg::ST_NULL)
  `ILFFA_ASSERT_IMP(a_copy_ok, out_valid && out_data.copy_valid, out_data.status == ilffa_pkg::ST_OK && out_data.result_address != 16'd0)

endmodule

bind implicit_list_first_fit_allocator_unit ilffa_checker u_ilffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
